FILE: hw/rtl/assert_macros.svh
// Concurrent assertion helpers; clocked on aclk, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check post in the cycle after pre.
`define NCS_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle check");

// Check post in the same cycle as pre.
`define NCS_ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle check");

`endif

FILE: hw/rtl/ncs_pkg.sv
package ncs_pkg;

    localparam int PIXEL_COUNT_BITS = 24;
    localparam int PIX_W   = 8;
    localparam int SUM_W   = PIXEL_COUNT_BITS + 16;
    localparam int PROD_W  = 2 * SUM_W;
    localparam int TRIAL_W = PROD_W + 34;
    localparam int SCORE_W = 17;
    localparam int BIT_W   = $clog2(SCORE_W);
    localparam int CNT_W   = $clog2(SUM_W);

    typedef struct packed {
        logic [SUM_W-1:0] cross_sum;
        logic [SUM_W-1:0] src_energy;
        logic [SUM_W-1:0] ref_energy;
        logic             overflow;
    } ncs_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ncs_qstat_t;

endpackage

FILE: hw/rtl/ncs_front.sv
module ncs_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ncs_pkg::PIX_W-1:0]    s_src_pixel,
    input  logic [ncs_pkg::PIX_W-1:0]    s_ref_pixel,
    input  logic                         s_last_pixel,
    input  ncs_pkg::ncs_qstat_t          qstat,
    output logic                         push,
    output ncs_pkg::ncs_entry_t          push_entry
);
    import ncs_pkg::*;

    logic [SUM_W-1:0] cross_reg, src_reg, ref_reg;
    logic             ovf_reg;
    logic [SUM_W:0]   cross_sat, src_sat, ref_sat;
    logic             ovf_now;
    logic             accept;

    // Saturating add; top bit flags saturation.
    function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] sum,
                                               input logic [2*PIX_W-1:0] p);
        logic [SUM_W:0] t;
        t = {1'b0, sum} + {{(SUM_W + 1 - 2 * PIX_W){1'b0}}, p};
        if (t[SUM_W]) begin
            sat_add = {1'b1, {SUM_W{1'b1}}};
        end else begin
            sat_add = t;
        end
    endfunction

    assign s_ready = !qstat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cross_sat = sat_add(cross_reg, (2*PIX_W)'(s_src_pixel) * (2*PIX_W)'(s_ref_pixel));
        src_sat   = sat_add(src_reg, (2*PIX_W)'(s_src_pixel) * (2*PIX_W)'(s_src_pixel));
        ref_sat   = sat_add(ref_reg, (2*PIX_W)'(s_ref_pixel) * (2*PIX_W)'(s_ref_pixel));
        ovf_now   = ovf_reg || cross_sat[SUM_W] || src_sat[SUM_W] || ref_sat[SUM_W];
        push                  = accept && s_last_pixel;
        push_entry.cross_sum  = cross_sat[SUM_W-1:0];
        push_entry.src_energy = src_sat[SUM_W-1:0];
        push_entry.ref_energy = ref_sat[SUM_W-1:0];
        push_entry.overflow   = ovf_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cross_reg <= '0;
            src_reg   <= '0;
            ref_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (accept) begin
            if (s_last_pixel) begin
                cross_reg <= '0;
                src_reg   <= '0;
                ref_reg   <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                cross_reg <= cross_sat[SUM_W-1:0];
                src_reg   <= src_sat[SUM_W-1:0];
                ref_reg   <= ref_sat[SUM_W-1:0];
                ovf_reg   <= ovf_now;
            end
        end
    end

endmodule

FILE: hw/rtl/ncs_queue.sv
module ncs_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ncs_pkg::ncs_entry_t push_entry,
    input  logic                pop,
    output logic                pop_valid,
    output ncs_pkg::ncs_entry_t pop_entry,
    output ncs_pkg::ncs_qstat_t qstat
);
    import ncs_pkg::*;

    ncs_entry_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign pop_valid   = !qstat.empty;
    assign pop_entry   = mem[rd_ptr_reg];
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hw/rtl/ncs_back.sv
module ncs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  ncs_pkg::ncs_entry_t           q_entry,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ncs_pkg::SCORE_W-1:0]   m_score,
    output logic                          m_overflow
);
    import ncs_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SETUP,
        B_ADD,
        B_CMP,
        B_DONE
    } back_state_t;

    back_state_t        state_reg;
    logic [SUM_W-1:0]   a_sh_reg, c_sh_reg;
    logic [PROD_W-1:0]  b_sh_reg, c_mc_reg, ab_reg, cc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TRIAL_W-1:0] ab2_reg, pp_reg, sq_reg, u_reg;
    logic [SCORE_W-1:0] q_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               ovf_keep_reg;
    logic               m_valid_reg, m_ovf_reg;
    logic [SCORE_W-1:0] m_score_reg;

    logic [TRIAL_W-1:0] trial, rhs;
    logic               take;

    assign q_pop      = (state_reg == B_IDLE) && q_valid;
    assign m_valid    = m_valid_reg;
    assign m_score    = m_score_reg;
    assign m_overflow = m_ovf_reg;

    always_comb begin
        rhs   = {2'b00, cc_reg, 32'd0};
        trial = u_reg + pp_reg;
        take  = !q_reg[SCORE_W-1] && (trial <= rhs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != B_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        ovf_keep_reg <= q_entry.overflow;
                        a_sh_reg     <= q_entry.src_energy;
                        b_sh_reg     <= {{SUM_W{1'b0}}, q_entry.ref_energy};
                        c_sh_reg     <= q_entry.cross_sum;
                        c_mc_reg     <= {{SUM_W{1'b0}}, q_entry.cross_sum};
                        ab_reg       <= '0;
                        cc_reg       <= '0;
                        cnt_reg      <= '0;
                        q_reg        <= '0;
                        if (q_entry.src_energy == '0 || q_entry.ref_energy == '0) begin
                            state_reg <= B_DONE;
                        end else begin
                            state_reg <= B_MUL;
                        end
                    end
                end
                B_MUL: begin
                    if (a_sh_reg[0]) begin
                        ab_reg <= ab_reg + b_sh_reg;
                    end
                    if (c_sh_reg[0]) begin
                        cc_reg <= cc_reg + c_mc_reg;
                    end
                    a_sh_reg <= a_sh_reg >> 1;
                    b_sh_reg <= b_sh_reg << 1;
                    c_sh_reg <= c_sh_reg >> 1;
                    c_mc_reg <= c_mc_reg << 1;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                        state_reg <= B_SETUP;
                    end
                end
                B_SETUP: begin
                    ab2_reg   <= {2'b00, ab_reg, 32'd0};
                    pp_reg    <= '0;
                    sq_reg    <= '0;
                    q_reg     <= '0;
                    bit_reg   <= BIT_W'(SCORE_W - 1);
                    state_reg <= B_ADD;
                end
                B_ADD: begin
                    u_reg     <= sq_reg + ab2_reg;
                    state_reg <= B_CMP;
                end
                B_CMP: begin
                    if (take) begin
                        sq_reg <= trial;
                        q_reg  <= q_reg | (SCORE_W'(1) << bit_reg);
                        pp_reg <= (pp_reg + (ab2_reg << 1)) >> 1;
                    end else begin
                        pp_reg <= pp_reg >> 1;
                    end
                    ab2_reg <= ab2_reg >> 2;
                    if (bit_reg == '0) begin
                        state_reg <= B_DONE;
                    end else begin
                        bit_reg   <= bit_reg - BIT_W'(1);
                        state_reg <= B_ADD;
                    end
                end
                B_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_score_reg <= q_reg;
                        m_ovf_reg   <= ovf_keep_reg;
                        state_reg   <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/normalized_correlation_score.sv
// Normalized cross-correlation of two 8-bit images streamed as pixel pairs. One pair
// transfers per cycle; the front keeps the three saturating sums and, on the pair marked
// last, hands them to a two-entry queue and clears. The back turns each queued image into
// a Q1.16 score: a bit-serial multiply of the sum products, one sum bit at a time, then a
// shift-and-add root search that resolves one score bit per add and compare step. An
// image with a zero energy sum skips both and scores zero. The score transfers from an
// output register, so the back starts the next image while a score waits. The input
// stalls only while two finished images are still queued.
`include "assert_macros.svh"

module normalized_correlation_score (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ncs_pkg::PIX_W-1:0]     s_src_pixel,
    input  logic [ncs_pkg::PIX_W-1:0]     s_ref_pixel,
    input  logic                          s_last_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ncs_pkg::SCORE_W-1:0]   m_score,
    output logic                          m_overflow
);
    import ncs_pkg::*;

    ncs_qstat_t qstat;
    ncs_entry_t push_entry, pop_entry;
    logic       push, pop, pop_valid;

    ncs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_src_pixel  (s_src_pixel),
        .s_ref_pixel  (s_ref_pixel),
        .s_last_pixel (s_last_pixel),
        .qstat        (qstat),
        .push         (push),
        .push_entry   (push_entry)
    );

    ncs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    ncs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (pop_valid),
        .q_entry    (pop_entry),
        .q_pop      (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_score    (m_score),
        .m_overflow (m_overflow)
    );

    `NCS_ASSERT_NEXT(a_image_queued, s_valid && s_ready && s_last_pixel, !qstat.empty)
    `NCS_ASSERT_SAME(a_score_clamped, m_valid && m_score[SCORE_W-1], m_score[SCORE_W-2:0] == '0)
    `NCS_ASSERT_SAME(a_push_has_room, push, !qstat.full)

endmodule
